>>> design/cau_pkg.sv
// cau_pkg: operation codes, cell modes and the control word that travels
// along the complex arithmetic unit pipeline. Used by every design file.
`default_nettype none
package cau_pkg;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4,
      OP_MOD  = 3'd5,
      OP_CMP  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_DIV  = 2'd1,
      MODE_SQRT = 2'd2
   } mode_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     neg_re;
      logic     neg_im;
      logic     sat_re;
      logic     sat_im;
      logic     equal;
      logic     div_error;
   } ctrl_type;

   localparam int unsigned TOL_WIDTH = 16;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_TOLERANCE = 2'd0;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

endpackage
`default_nettype wire

>>> design/complex_arithmetic_unit.sv
// complex_arithmetic_unit: fixed point complex ALU, top level.
// Stages from accept to result: input register, multiply stage, prep stage,
// one digit cell per result bit, output register.
// Throughput one transaction per cycle while rsp_stall is low; every stage moves on
// when the next one is empty or moving, so bubbles close up under stall.
// Synchronous reset empties the pipeline and sets tolerance to 1.
`default_nettype none
module complex_arithmetic_unit #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire [2:0]                             req_operation,
   input  wire signed [DATA_WIDTH-1:0]           req_a_re,
   input  wire signed [DATA_WIDTH-1:0]           req_a_im,
   input  wire signed [DATA_WIDTH-1:0]           req_b_re,
   input  wire signed [DATA_WIDTH-1:0]           req_b_im,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [DATA_WIDTH-1:0]          rsp_res_re,
   output logic signed [DATA_WIDTH-1:0]          rsp_res_im,
   output logic                                  rsp_equal,
   output logic                                  rsp_div_error,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire [cau_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  wire [cau_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [cau_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready
);

   localparam int DW = DATA_WIDTH;
   localparam int RW = 2*DW + ((DW > FRAC_BITS) ? DW : FRAC_BITS) + 1;
   localparam int NST = DW + 4;
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   // configuration
   logic [cau_pkg::TOL_WIDTH-1:0] tol_ff;
   logic                          csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = cau_pkg::CSR_DATA_WIDTH'(tol_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= cau_pkg::TOL_RESET;
      end else if (csr_wr && (paddr == cau_pkg::ADDR_TOLERANCE)) begin
         tol_ff <= pwdata[cau_pkg::TOL_WIDTH-1:0];
      end
   end

   // stage s loads when its own register is empty or the next stage loads
   logic [NST-1:0] stage_valid;
   logic [NST:0]   en;

   assign en[NST] = !rsp_stall;
   for (genvar s = 0; s < NST; s++) begin : g_en
      assign en[s] = !stage_valid[s] || en[s+1];
   end
   assign req_stall = !en[0];

   // input register
   logic                  a_valid_ff;
   logic [2:0]            a_op_ff;
   logic signed [DW-1:0]  a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en[0]) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_op_ff <= req_operation;
         a_ar_ff <= req_a_re;
         a_ai_ff <= req_a_im;
         a_br_ff <= req_b_re;
         a_bi_ff <= req_b_im;
      end
   end

   // multiply stage; modulus squares a through the first two multipliers
   logic                   b_valid_ff;
   logic [2:0]             b_op_ff;
   logic signed [DW-1:0]   b_ar_ff, b_ai_ff, b_br_ff, b_bi_ff;
   logic signed [DW-1:0]   x0, x1;
   logic signed [2*DW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;

   assign x0 = (a_op_ff == cau_pkg::OP_MOD) ? a_ar_ff : a_br_ff;
   assign x1 = (a_op_ff == cau_pkg::OP_MOD) ? a_ai_ff : a_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en[1]) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         b_op_ff <= a_op_ff;
         b_ar_ff <= a_ar_ff;
         b_ai_ff <= a_ai_ff;
         b_br_ff <= a_br_ff;
         b_bi_ff <= a_bi_ff;
         m0_ff   <= a_ar_ff * x0;
         m1_ff   <= a_ai_ff * x1;
         m2_ff   <= a_ar_ff * a_bi_ff;
         m3_ff   <= a_ai_ff * a_br_ff;
         m4_ff   <= a_br_ff * a_br_ff;
         m5_ff   <= a_bi_ff * a_bi_ff;
      end
   end

   // cell chain, index 0 is the prep stage output
   cau_pkg::ctrl_type ch_ctrl [DW+1];
   logic [RW-1:0]     ch_rem0 [DW+1];
   logic [RW-1:0]     ch_rem1 [DW+1];
   logic [DW-1:0]     ch_q0   [DW+1];
   logic [DW-1:0]     ch_q1   [DW+1];
   logic [2*DW-1:0]   ch_den  [DW+1];

   cau_prep #(.DW(DW), .FW(FRAC_BITS), .RW(RW)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en[2]),
      .in_valid  (b_valid_ff),
      .op        (b_op_ff),
      .ar        (b_ar_ff),
      .ai        (b_ai_ff),
      .br        (b_br_ff),
      .bi        (b_bi_ff),
      .m0        (m0_ff),
      .m1        (m1_ff),
      .m2        (m2_ff),
      .m3        (m3_ff),
      .m4        (m4_ff),
      .m5        (m5_ff),
      .tolerance (tol_ff),
      .ctrl_out  (ch_ctrl[0]),
      .rem0_out  (ch_rem0[0]),
      .rem1_out  (ch_rem1[0]),
      .q0_out    (ch_q0[0]),
      .q1_out    (ch_q1[0]),
      .den_out   (ch_den[0])
   );

   for (genvar i = 0; i < DW; i++) begin : g_cell
      cau_cell #(.DW(DW), .RW(RW), .K(DW-1-i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en[3+i]),
         .ctrl_in  (ch_ctrl[i]),
         .rem0_in  (ch_rem0[i]),
         .rem1_in  (ch_rem1[i]),
         .q0_in    (ch_q0[i]),
         .q1_in    (ch_q1[i]),
         .den_in   (ch_den[i]),
         .ctrl_out (ch_ctrl[i+1]),
         .rem0_out (ch_rem0[i+1]),
         .rem1_out (ch_rem1[i+1]),
         .q0_out   (ch_q0[i+1]),
         .q1_out   (ch_q1[i+1]),
         .den_out  (ch_den[i+1])
      );
      assign stage_valid[3+i] = ch_ctrl[i+1].valid;
   end

   assign stage_valid[0] = a_valid_ff;
   assign stage_valid[1] = b_valid_ff;
   assign stage_valid[2] = ch_ctrl[0].valid;
   assign stage_valid[NST-1] = rsp_valid;

   // output register
   cau_pkg::ctrl_type fin;
   logic [DW-1:0]     fq0, fq1, re_in, im_in;
   logic              big_re, big_im;
   logic              rsp_valid_ff, eq_ff, err_ff;
   logic [DW-1:0]     re_ff, im_ff;

   always_comb begin
      fin = ch_ctrl[DW];
      fq0 = ch_q0[DW];
      fq1 = ch_q1[DW];
      big_re = fin.sat_re || fq0[DW-1];
      big_im = fin.sat_im || fq1[DW-1];
      unique case (fin.mode)
         cau_pkg::MODE_DIV: begin
            if (big_re) re_in = fin.neg_re ? MINV : MAXV;
            else        re_in = fin.neg_re ? DW'(-fq0) : fq0;
            if (big_im) im_in = fin.neg_im ? MINV : MAXV;
            else        im_in = fin.neg_im ? DW'(-fq1) : fq1;
         end
         cau_pkg::MODE_SQRT: begin
            re_in = fq0[DW-1] ? MAXV : fq0;
            im_in = '0;
         end
         default: begin
            re_in = fq0;
            im_in = fq1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[NST-1]) begin
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         re_ff  <= re_in;
         im_ff  <= im_in;
         eq_ff  <= fin.equal;
         err_ff <= fin.div_error;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_re    = re_ff;
   assign rsp_res_im    = im_ff;
   assign rsp_equal     = eq_ff;
   assign rsp_div_error = err_ff;

`ifndef SYNTH
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |-> (rsp_res_re == '0 && rsp_res_im == '0))
      else $error("div_error transaction with nonzero result");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_equal && rsp_div_error))
      else $error("equal and div_error both set");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output register");

   a_tol_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && paddr == cau_pkg::ADDR_TOLERANCE)
         |=> (tol_ff == $past(pwdata[cau_pkg::TOL_WIDTH-1:0])))
      else $error("tolerance write lost");
`endif

endmodule
`default_nettype wire

>>> design/cau_prep.sv
// cau_prep: turns operands and registered products into the word that enters
// the digit cells; add, sub, mul, conjugate and compare finish here.
// Depends on cau_pkg.
`default_nettype none
module cau_prep #(
   parameter int DW = 32,
   parameter int FW = 16,
   parameter int RW = 97
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           en,
   input  wire                           in_valid,
   input  wire [2:0]                     op,
   input  wire signed [DW-1:0]           ar,
   input  wire signed [DW-1:0]           ai,
   input  wire signed [DW-1:0]           br,
   input  wire signed [DW-1:0]           bi,
   input  wire signed [2*DW-1:0]         m0,
   input  wire signed [2*DW-1:0]         m1,
   input  wire signed [2*DW-1:0]         m2,
   input  wire signed [2*DW-1:0]         m3,
   input  wire signed [2*DW-1:0]         m4,
   input  wire signed [2*DW-1:0]         m5,
   input  wire [cau_pkg::TOL_WIDTH-1:0]  tolerance,
   output cau_pkg::ctrl_type             ctrl_out,
   output logic [RW-1:0]                 rem0_out,
   output logic [RW-1:0]                 rem1_out,
   output logic [DW-1:0]                 q0_out,
   output logic [DW-1:0]                 q1_out,
   output logic [2*DW-1:0]               den_out
);

   localparam int SW = 2*DW + 2;
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   function automatic logic [DW-1:0] sat_w(input logic signed [SW-1:0] x);
      logic [SW-DW:0] top;
      top = x[SW-1:DW-1];
      if ((&top) || !(|top)) return x[DW-1:0];
      return x[SW-1] ? MINV : MAXV;
   endfunction

   function automatic logic [SW-1:0] abs_w(input logic signed [SW-1:0] x);
      return x[SW-1] ? SW'(-x) : SW'(x);
   endfunction

   cau_pkg::ctrl_type     ctrl_in, ctrl_ff;
   logic [RW-1:0]         rem0_in, rem1_in, rem0_ff, rem1_ff;
   logic [DW-1:0]         q0_in, q1_in, q0_ff, q1_ff;
   logic [2*DW-1:0]       den_in, den_ff;

   logic signed [SW-1:0]  ar_x, ai_x, br_x, bi_x;
   logic signed [SW-1:0]  sum_re, sum_im, dif_re, dif_im;
   logic signed [SW-1:0]  mul_re, mul_im, num_re, num_im;
   logic [SW-1:0]         den_s, tol_x;
   logic [RW-1:0]         nre_rw, nim_rw, den_lim;
   logic                  eq_hit, zero_div;

   always_comb begin
      ar_x   = SW'(ar);
      ai_x   = SW'(ai);
      br_x   = SW'(br);
      bi_x   = SW'(bi);
      tol_x  = SW'(tolerance);
      sum_re = ar_x + br_x;
      sum_im = ai_x + bi_x;
      dif_re = ar_x - br_x;
      dif_im = ai_x - bi_x;
      mul_re = (SW'(m0) - SW'(m1)) >>> FW;
      mul_im = (SW'(m2) + SW'(m3)) >>> FW;
      num_re = SW'(m0) + SW'(m1);
      num_im = SW'(m3) - SW'(m2);
      den_s  = SW'(m4) + SW'(m5);
      nre_rw = RW'(abs_w(num_re)) << FW;
      nim_rw = RW'(abs_w(num_im)) << FW;
      den_lim = RW'(den_s) << DW;
      eq_hit = (abs_w(dif_re) < tol_x) && (abs_w(dif_im) < tol_x);
      zero_div = ((abs_w(br_x) < tol_x) && (abs_w(bi_x) < tol_x)) || (den_s == '0);

      ctrl_in = '0;
      ctrl_in.valid = in_valid;
      ctrl_in.mode = cau_pkg::MODE_PASS;
      rem0_in = '0;
      rem1_in = '0;
      q0_in = '0;
      q1_in = '0;
      den_in = '0;
      unique case (op)
         cau_pkg::OP_ADD: begin
            q0_in = sat_w(sum_re);
            q1_in = sat_w(sum_im);
         end
         cau_pkg::OP_SUB: begin
            q0_in = sat_w(dif_re);
            q1_in = sat_w(dif_im);
         end
         cau_pkg::OP_MUL: begin
            q0_in = sat_w(mul_re);
            q1_in = sat_w(mul_im);
         end
         cau_pkg::OP_DIV: begin
            if (zero_div) begin
               ctrl_in.div_error = 1'b1;
            end else begin
               ctrl_in.mode   = cau_pkg::MODE_DIV;
               ctrl_in.neg_re = num_re[SW-1];
               ctrl_in.neg_im = num_im[SW-1];
               ctrl_in.sat_re = nre_rw >= den_lim;
               ctrl_in.sat_im = nim_rw >= den_lim;
               rem0_in = nre_rw;
               rem1_in = nim_rw;
               den_in  = den_s[2*DW-1:0];
            end
         end
         cau_pkg::OP_CONJ: begin
            q0_in = ar;
            q1_in = sat_w(-ai_x);
         end
         cau_pkg::OP_MOD: begin
            ctrl_in.mode = cau_pkg::MODE_SQRT;
            rem0_in = RW'(num_re[2*DW-1:0]);
         end
         cau_pkg::OP_CMP: begin
            ctrl_in.equal = eq_hit;
         end
         default: begin
            q0_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff <= rem0_in;
         rem1_ff <= rem1_in;
         q0_ff   <= q0_in;
         q1_ff   <= q1_in;
         den_ff  <= den_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem0_out = rem0_ff;
   assign rem1_out = rem1_ff;
   assign q0_out   = q0_ff;
   assign q1_out   = q1_ff;
   assign den_out  = den_ff;

endmodule
`default_nettype wire

>>> design/cau_cell.sv
// cau_cell: one digit cell of the divide / square root chain; settles result
// bit K of both lanes in divide mode and of lane 0 in square root mode. Depends on cau_pkg.
`default_nettype none
module cau_cell #(
   parameter int DW = 32,
   parameter int RW = 97,
   parameter int K  = 0
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  cau_pkg::ctrl_type    ctrl_in,
   input  wire [RW-1:0]         rem0_in,
   input  wire [RW-1:0]         rem1_in,
   input  wire [DW-1:0]         q0_in,
   input  wire [DW-1:0]         q1_in,
   input  wire [2*DW-1:0]       den_in,
   output cau_pkg::ctrl_type    ctrl_out,
   output logic [RW-1:0]        rem0_out,
   output logic [RW-1:0]        rem1_out,
   output logic [DW-1:0]        q0_out,
   output logic [DW-1:0]        q1_out,
   output logic [2*DW-1:0]      den_out
);

   localparam logic [RW-1:0] SQ_BIT = RW'(1) << (2*K);
   localparam logic [DW-1:0] Q_BIT  = DW'(1) << K;

   cau_pkg::ctrl_type ctrl_ff;
   logic [RW-1:0]     rem0_ff, rem1_ff, t0, t1;
   logic [DW-1:0]     q0_ff, q1_ff;
   logic [2*DW-1:0]   den_ff;
   logic [RW-1:0]     rem0_nx, rem1_nx;
   logic [DW-1:0]     q0_nx, q1_nx;
   logic              hit0, hit1;

   always_comb begin
      t1 = RW'(den_in) << K;
      // square root tests (2*root + 2^K) * 2^K against the remainder
      if (ctrl_in.mode == cau_pkg::MODE_SQRT) begin
         t0 = (RW'(q0_in) << (K + 1)) + SQ_BIT;
      end else begin
         t0 = t1;
      end
      hit0 = rem0_in >= t0;
      hit1 = rem1_in >= t1;
      rem0_nx = rem0_in;
      rem1_nx = rem1_in;
      q0_nx = q0_in;
      q1_nx = q1_in;
      unique case (ctrl_in.mode)
         cau_pkg::MODE_DIV: begin
            if (hit0) begin
               rem0_nx = rem0_in - t0;
               q0_nx = q0_in | Q_BIT;
            end
            if (hit1) begin
               rem1_nx = rem1_in - t1;
               q1_nx = q1_in | Q_BIT;
            end
         end
         cau_pkg::MODE_SQRT: begin
            if (hit0) begin
               rem0_nx = rem0_in - t0;
               q0_nx = q0_in | Q_BIT;
            end
         end
         default: begin
            q0_nx = q0_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff <= rem0_nx;
         rem1_ff <= rem1_nx;
         q0_ff   <= q0_nx;
         q1_ff   <= q1_nx;
         den_ff  <= den_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem0_out = rem0_ff;
   assign rem1_out = rem1_ff;
   assign q0_out   = q0_ff;
   assign q1_out   = q1_ff;
   assign den_out  = den_ff;

endmodule
`default_nettype wire

>>> tb/sv/cau_checker.sv
// cau_checker: watches the request and response channels of the complex
// arithmetic unit, predicts each result in Q16.16 and compares. Uses cau_pkg.
`timescale 1ns / 1ps
module cau_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   input  wire          req_stall,
   input  wire [2:0]    req_operation,
   input  wire [31:0]   req_a_re,
   input  wire [31:0]   req_a_im,
   input  wire [31:0]   req_b_re,
   input  wire [31:0]   req_b_im,
   input  wire          rsp_valid,
   input  wire          rsp_stall,
   input  wire [31:0]   rsp_res_re,
   input  wire [31:0]   rsp_res_im,
   input  wire          rsp_equal,
   input  wire          rsp_div_error,
   input  wire [15:0]   tolerance,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        eq;
      logic        err;
   } cplx_result;

   cplx_result expected_results[$];
   int result_count;

   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;

   function automatic logic [31:0] clamp(input logic signed [127:0] x);
      if (x > 128'sd2147483647) return MAXV;
      if (x < -128'sd2147483648) return MINV;
      return x[31:0];
   endfunction

   function automatic logic tol_zero(input logic signed [127:0] x, input logic [15:0] tol);
      logic signed [127:0] m;
      m = (x < 0) ? -x : x;
      return m < $signed({112'd0, tol});
   endfunction

   // truncate toward zero: n * 2^16 / d, d positive
   function automatic logic [31:0] frac_quot(input logic signed [127:0] n,
                                             input logic signed [127:0] d);
      logic signed [127:0] mag, q;
      mag = (n < 0) ? -n : n;
      q = (mag <<< 16) / d;
      return clamp((n < 0) ? -q : q);
   endfunction

   function automatic logic [31:0] floor_sqrt(input logic [127:0] v);
      logic [127:0] r, b;
      r = 0;
      b = 128'd1 << 126;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else r = r >> 1;
         b = b >> 2;
      end
      return clamp($signed(r));
   endfunction

   function automatic cplx_result predict_alu(input logic [2:0] op,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi,
      input logic [15:0] tol);
      cplx_result r;
      logic signed [127:0] xr, xi, yr, yi, den;
      r = '0;
      xr = ar; xi = ai; yr = br; yi = bi;
      case (op)
         cau_pkg::OP_ADD: begin r.re = clamp(xr + yr); r.im = clamp(xi + yi); end
         cau_pkg::OP_SUB: begin r.re = clamp(xr - yr); r.im = clamp(xi - yi); end
         cau_pkg::OP_MUL: begin
            r.re = clamp((xr * yr - xi * yi) >>> 16);
            r.im = clamp((xr * yi + xi * yr) >>> 16);
         end
         cau_pkg::OP_DIV: begin
            den = yr * yr + yi * yi;
            if ((tol_zero(yr, tol) && tol_zero(yi, tol)) || den == 0) r.err = 1'b1;
            else begin
               r.re = frac_quot(xr * yr + xi * yi, den);
               r.im = frac_quot(xi * yr - xr * yi, den);
            end
         end
         cau_pkg::OP_CONJ: begin r.re = clamp(xr); r.im = clamp(-xi); end
         cau_pkg::OP_MOD: r.re = floor_sqrt(xr * xr + xi * xi);
         cau_pkg::OP_CMP: r.eq = tol_zero(xr - yr, tol) && tol_zero(xi - yi, tol);
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", result_count, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      result_count = 0;
   end

   assign pending = expected_results.size();

   always @(posedge clock) begin
      cplx_result want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_results.push_back(predict_alu(req_operation, req_a_re, req_a_im,
                                                   req_b_re, req_b_im, tolerance));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction", 32'h0, 32'h0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_res_re !== want.re) report_mismatch("res_re", rsp_res_re, want.re);
               if (rsp_res_im !== want.im) report_mismatch("res_im", rsp_res_im, want.im);
               if (rsp_equal !== want.eq) report_mismatch("equal", rsp_equal, want.eq);
               if (rsp_div_error !== want.err)
                  report_mismatch("div_error", rsp_div_error, want.err);
            end
            result_count++;
         end
      end
   end
endmodule

>>> tb/sv/testbench.sv
// testbench: stimulus, tolerance programming and verdict for the complex
// arithmetic unit. Depends on cau_pkg, complex_arithmetic_unit, cau_checker.
`timescale 1ns / 1ps
module testbench;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_operation;
   logic [31:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic rsp_valid, rsp_stall;
   logic [31:0] rsp_res_re, rsp_res_im;
   logic rsp_equal, rsp_div_error;
   logic psel, penable, pwrite;
   logic [cau_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [cau_pkg::CSR_DATA_WIDTH-1:0] pwdata, prdata;
   logic pready;
   logic [15:0] tolerance;
   int fail_count, pending;
   int hold_off;
   bit stall_enable;

   complex_arithmetic_unit dut (.*);

   cau_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver: random stalls, random long hold-offs and one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off--;
         end else if (!stall_enable) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 3) == 0) rsp_stall <= 1'b1;
         else if ($urandom_range(0, 40) == 0) begin
            rsp_stall <= 1'b1;
            hold_off = $urandom_range(10, 60);
         end else rsp_stall <= 1'b0;
      end
   end

   task automatic write_tolerance(input logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= cau_pkg::ADDR_TOLERANCE; pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      tolerance = value;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // valid stays high after the accept so the next transaction can follow
   task automatic send_item(input logic [2:0] op, input logic [31:0] ar,
      input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi,
      input bit gaps);
      int gap;
      gap = 0;
      if (gaps) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         if ($urandom_range(0, 2) == 0) gap = 0;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op; req_a_re <= ar; req_a_im <= ai; req_b_re <= br; req_b_im <= bi;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 8) << 16;
         2: return -($urandom_range(0, 8) << 16);
         3: return $signed($urandom_range(0, 200)) - 100;
         4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $signed($urandom()) >>> $urandom_range(4, 20);
      endcase
   endfunction

   initial begin
      logic [31:0] ext [6];
      logic [2:0] op;
      logic [31:0] ar, ai;
      int n;
      ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000, 32'hffff0000, 32'h1};
      reset = 1'b1; req_valid = 0; req_operation = 0;
      req_a_re = 0; req_a_im = 0; req_b_re = 0; req_b_im = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      tolerance = cau_pkg::TOL_RESET; hold_off = 0; stall_enable = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, each operation, zero divisor, unused code
      for (int k = 0; k < 7; k++)
         send_item(cau_pkg::op_type'(k), ext[0], ext[1], ext[k % 6], ext[(k + 2) % 6], 0);
      send_item(cau_pkg::OP_CONJ, ext[1], ext[1], 0, 0, 0);
      send_item(cau_pkg::OP_MOD, ext[1], ext[1], 0, 0, 0);
      send_item(cau_pkg::OP_MUL, ext[1], ext[1], ext[1], ext[0], 0);
      send_item(cau_pkg::OP_DIV, ext[0], ext[0], 0, 0, 0);
      send_item(cau_pkg::OP_DIV, ext[0], ext[1], 1, 0, 0);
      send_item(cau_pkg::OP_DIV, ext[3], ext[3], ext[5], ext[5], 0);
      send_item(cau_pkg::OP_DIV, ext[0], 0, 32'h00000100, 0, 0);
      send_item(cau_pkg::OP_CMP, ext[3], ext[3], ext[3], ext[3], 0);
      send_item(cau_pkg::OP_CMP, ext[0], ext[1], ext[1], ext[0], 0);
      send_item(3'd7, ext[0], ext[0], ext[0], ext[0], 0);
      send_item(cau_pkg::OP_SUB, ext[1], ext[0], ext[0], ext[1], 0);
      drain();
      write_tolerance(16'd0);
      send_item(cau_pkg::OP_DIV, 5, 5, 0, 0, 0);
      send_item(cau_pkg::OP_DIV, 5, 5, 0, 1, 0);
      send_item(cau_pkg::OP_CMP, 5, 5, 5, 5, 0);
      drain();
      write_tolerance(16'hffff);
      send_item(cau_pkg::OP_DIV, ext[3], 0, 32'h0000ff00, 32'hffff0100, 0);
      send_item(cau_pkg::OP_CMP, 0, 0, 32'h0000fffe, 32'hffff0002, 0);
      stall_enable = 1;
      // random phases over several tolerance settings
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         write_tolerance(phase == 5 ? 16'd1 : 16'($urandom_range(0, 65535) >> (4 * phase % 16)));
         if (phase == 2) hold_off = 300; // long receiver hold-off while we keep sending
         for (n = 0; n < 320; n++) begin
            op = 3'($urandom_range(0, 7));
            ar = rand_operand(); ai = rand_operand();
            if (op == cau_pkg::OP_CMP && $urandom_range(0, 1))
               send_item(op, ar, ai, ar + $signed($urandom_range(0, 40)) - 20,
                         ai + $signed($urandom_range(0, 40)) - 20, phase != 2);
            else
               send_item(op, ar, ai, rand_operand(),
                         $urandom_range(0, 4) == 0 ? 32'h0 : rand_operand(), phase != 2);
         end
      end
      drain();
      $display("covered all seven operations plus the unused code, saturation extremes,");
      $display("zero divisors and compares over tolerances 0, 1, 65535 and random values");
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
